// ===== src/ihsp_pkg.sv =====
// Package for the image header size parser.
// Holds shared types, byte constants and format codes; no dependencies.
package ihsp_pkg;

    // Result format codes
    typedef enum logic [1:0] {
        FMT_JPEG = 2'd0,
        FMT_GIF  = 2'd1,
        FMT_PNG  = 2'd2,
        FMT_NONE = 2'd3
    } format_t;

    // Status codes
    localparam logic ST_FOUND = 1'b0;
    localparam logic ST_FAIL  = 1'b1;

    // Marker and signature bytes
    localparam logic [7:0] B_FF    = 8'hFF;
    localparam logic [7:0] B_SOI   = 8'hD8;
    localparam logic [7:0] B_APP0  = 8'hE0;
    localparam logic [7:0] B_SOF0  = 8'hC0;
    localparam logic [7:0] B_SOF3  = 8'hC3;
    localparam logic [7:0] B_SOF9  = 8'hC9;
    localparam logic [7:0] B_SOF11 = 8'hCB;
    localparam logic [7:0] B_PNG0  = 8'h89;
    localparam logic [7:0] B_SUB   = 8'h1A;
    localparam logic [7:0] B_CR    = 8'h0D;
    localparam logic [7:0] B_LF    = 8'h0A;
    localparam logic [7:0] C_J     = 8'h4A;
    localparam logic [7:0] C_F     = 8'h46;
    localparam logic [7:0] C_I     = 8'h49;
    localparam logic [7:0] C_G     = 8'h47;
    localparam logic [7:0] C_P     = 8'h50;
    localparam logic [7:0] C_N     = 8'h4E;
    localparam logic [7:0] C_H     = 8'h48;
    localparam logic [7:0] C_D     = 8'h44;
    localparam logic [7:0] C_R     = 8'h52;

    // Header and window geometry
    localparam int HEADER_LEN = 24;
    localparam int WINDOW_LEN = 12;
    localparam int FIRST_WINDOW_END = 13;

    typedef logic [HEADER_LEN-1:0][7:0] header_t;
    typedef logic [WINDOW_LEN-1:0][7:0] window_t;

    // Walk state of the marker segment scan
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_DONE = 3'b100
    } scan_phase_t;

    // Header view handed from the tracker to the decoder
    typedef struct packed {
        header_t bytes;
        logic    long_enough;
    } view_t;

    // One result word
    typedef struct packed {
        logic        status;
        format_t     format;
        logic [31:0] width;
        logic [31:0] height;
    } result_t;

endpackage

// ===== src/ihsp_byte_if.sv =====
// Byte stream channel: valid/ready handshake with one file byte and a last mark.
// Stands alone; no package needed.
interface ihsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== src/ihsp_result_if.sv =====
// Result channel: valid/ready handshake with status, format and image size.
// Stands alone; no package needed.
interface ihsp_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [1:0]  format;
    logic [31:0] width;
    logic [31:0] height;

    modport source (output valid, output status, output format, output width,
                    output height, input ready);
    modport sink   (input valid, input status, input format, input width,
                    input height, output ready);
endinterface

// ===== src/image_header_size_parser.sv =====
// Image header size parser, top level: input word register, tracker, decoder, result register.
// Depends on ihsp_pkg, ihsp_byte_if, ihsp_result_if, ihsp_track and ihsp_decode.
//
// Takes an image file one byte word per cycle and, on the word marked last, delivers one
// result word with status, format (JPEG, GIF, PNG or none) and width and height. A byte
// word is taken every cycle, also while a finished result waits to be taken; only a last
// word stalls, and only while the result register still holds an untaken result. The last
// byte goes from the input register through the tracker and decoder into the result
// register. The cycle is set by the segment walk, which adds each JPEG segment length to
// the OFFSET_BITS-wide window end and compares that end with the byte count. Files shorter
// than 24 bytes report failure.
module image_header_size_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    ihsp_byte_if.sink       file_bytes,
    ihsp_result_if.source   size_info
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    ihsp_pkg::result_t out_reg;

    logic              advance;
    ihsp_pkg::view_t   view;
    ihsp_pkg::result_t result;

    // Move a word on unless it is a last word facing a full result register
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || size_info.ready);
    assign file_bytes.ready = !in_valid_reg || advance;

    ihsp_track #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .view      (view)
    );

    ihsp_decode u_decode (
        .view   (view),
        .result (result)
    );

    // Input and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (file_bytes.valid && file_bytes.ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (size_info.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture input word and result payloads
    always_ff @(posedge clk)
    begin
        if (file_bytes.valid && file_bytes.ready)
        begin
            in_byte_reg <= file_bytes.data_byte;
            in_last_reg <= file_bytes.last;
        end
        if (advance && in_last_reg)
            out_reg <= result;
    end

    assign size_info.valid  = out_valid_reg;
    assign size_info.status = out_reg.status;
    assign size_info.format = out_reg.format;
    assign size_info.width  = out_reg.width;
    assign size_info.height = out_reg.height;

    // A result appears only after a last word went through
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result appeared without a last word");

    // A last word never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |-> !out_valid_reg || size_info.ready)
        else $error("untaken result overwritten");

    // A found size always names a format
    a_found_has_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ihsp_pkg::ST_FOUND
            |-> out_reg.format != ihsp_pkg::FMT_NONE)
        else $error("found status without a format");

endmodule

// ===== src/ihsp_track.sv =====
// Byte tracker: header store, byte history, JPEG segment walk and byte count.
// Depends on ihsp_pkg for types and constants.
module ihsp_track #(
    parameter int OFFSET_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last,
    output ihsp_pkg::view_t   view
);

    logic [OFFSET_BITS-1:0]   offset_reg, offset_next;
    logic [OFFSET_BITS-1:0]   win_end_reg, win_end_next;
    ihsp_pkg::scan_phase_t    phase_reg, phase_next;
    ihsp_pkg::header_t        hs_reg, hs_next;
    ihsp_pkg::window_t        win_reg, win_next;
    ihsp_pkg::window_t        hist_reg, hist_next;

    logic                     load_first;
    logic                     load_walk;
    logic                     jfif;
    logic                     win_bad;
    logic [16:0]              seg_step;
    logic [OFFSET_BITS:0]     end_sum;
    ihsp_pkg::window_t        jw;

    // Write the current byte into the header store and the history
    always_comb
    begin
        for (int i = 0; i < ihsp_pkg::HEADER_LEN; i++)
        begin
            if (offset_reg < OFFSET_BITS'(ihsp_pkg::HEADER_LEN) && offset_reg[4:0] == 5'(i))
                hs_next[i] = data_byte;
            else
                hs_next[i] = hs_reg[i];
        end
        for (int i = 0; i < ihsp_pkg::WINDOW_LEN - 1; i++)
            hist_next[i] = hist_reg[i+1];
        hist_next[ihsp_pkg::WINDOW_LEN-1] = data_byte;
    end

    // Judge a complete window and aim at the next segment
    always_comb
    begin
        load_first = offset_reg == OFFSET_BITS'(ihsp_pkg::FIRST_WINDOW_END);
        load_walk  = (phase_reg == ihsp_pkg::PH_WAIT) && (offset_reg == win_end_reg);
        jw         = load_first ? hs_next[13:2] : hist_next;

        jfif = hs_next[0] == ihsp_pkg::B_FF && hs_next[1] == ihsp_pkg::B_SOI &&
               hs_next[2] == ihsp_pkg::B_FF && hs_next[3] == ihsp_pkg::B_APP0 &&
               hs_next[6] == ihsp_pkg::C_J  && hs_next[7] == ihsp_pkg::C_F &&
               hs_next[8] == ihsp_pkg::C_I  && hs_next[9] == ihsp_pkg::C_F;

        win_bad = jw[0] != ihsp_pkg::B_FF ||
                  (jw[1] >= ihsp_pkg::B_SOF0 && jw[1] <= ihsp_pkg::B_SOF3) ||
                  (jw[1] >= ihsp_pkg::B_SOF9 && jw[1] <= ihsp_pkg::B_SOF11);
        seg_step = {1'b0, jw[2], jw[3]} + 17'd2;
        end_sum  = {1'b0, win_end_reg} + (OFFSET_BITS+1)'(seg_step);

        win_next     = win_reg;
        win_end_next = win_end_reg;
        phase_next   = phase_reg;
        if (load_first || load_walk)
        begin
            win_next = jw;
            if (load_first && !jfif)
                phase_next = ihsp_pkg::PH_DONE;
            else if (win_bad || end_sum[OFFSET_BITS])
                phase_next = ihsp_pkg::PH_DONE;
            else
            begin
                win_end_next = end_sum[OFFSET_BITS-1:0];
                phase_next   = ihsp_pkg::PH_WAIT;
            end
        end

        // Saturate the byte count
        if (&offset_reg)
            offset_next = offset_reg;
        else
            offset_next = offset_reg + OFFSET_BITS'(1);
    end

    // Present the header view with this byte already applied
    always_comb
    begin
        view.bytes        = hs_next;
        view.bytes[13:2]  = win_next;
        view.long_enough  = offset_reg >= OFFSET_BITS'(ihsp_pkg::HEADER_LEN - 1);
    end

    // Advance control state; clear it after the last byte of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            win_end_reg <= OFFSET_BITS'(ihsp_pkg::FIRST_WINDOW_END);
            phase_reg   <= ihsp_pkg::PH_IDLE;
        end
        else if (step)
        begin
            if (last)
            begin
                offset_reg  <= '0;
                win_end_reg <= OFFSET_BITS'(ihsp_pkg::FIRST_WINDOW_END);
                phase_reg   <= ihsp_pkg::PH_IDLE;
            end
            else
            begin
                offset_reg  <= offset_next;
                win_end_reg <= win_end_next;
                phase_reg   <= phase_next;
            end
        end
    end

    // Hold stored bytes
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hs_reg   <= hs_next;
            win_reg  <= win_next;
            hist_reg <= hist_next;
        end
    end

    // A pending window never lies behind the byte count
    a_wait_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ihsp_pkg::PH_WAIT |-> win_end_reg >= offset_reg)
        else $error("pending segment window lies behind byte count");

    // The end of a file returns the walk to its start
    a_file_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> offset_reg == '0 && phase_reg == ihsp_pkg::PH_IDLE)
        else $error("tracker not cleared after last byte");

endmodule

// ===== src/ihsp_decode.sv =====
// Header decoder: picks JPEG, GIF or PNG from the header view and extracts size.
// Depends on ihsp_pkg for types and constants.
module ihsp_decode (
    input  ihsp_pkg::view_t   view,
    output ihsp_pkg::result_t result
);

    ihsp_pkg::header_t v;
    logic              is_jpeg;
    logic              is_gif;
    logic              is_png;

    // Match signatures
    always_comb
    begin
        v       = view.bytes;
        is_jpeg = v[0] == ihsp_pkg::B_FF && v[1] == ihsp_pkg::B_SOI &&
                  v[2] == ihsp_pkg::B_FF;
        is_gif  = v[0] == ihsp_pkg::C_G && v[1] == ihsp_pkg::C_I && v[2] == ihsp_pkg::C_F;
        is_png  = v[0] == ihsp_pkg::B_PNG0 && v[1] == ihsp_pkg::C_P &&
                  v[2] == ihsp_pkg::C_N && v[3] == ihsp_pkg::C_G &&
                  v[4] == ihsp_pkg::B_CR && v[5] == ihsp_pkg::B_LF &&
                  v[6] == ihsp_pkg::B_SUB && v[7] == ihsp_pkg::B_LF &&
                  v[12] == ihsp_pkg::C_I && v[13] == ihsp_pkg::C_H &&
                  v[14] == ihsp_pkg::C_D && v[15] == ihsp_pkg::C_R;
    end

    // Extract width and height in the format's byte order
    always_comb
    begin
        result.status = ihsp_pkg::ST_FAIL;
        result.format = ihsp_pkg::FMT_NONE;
        result.width  = '0;
        result.height = '0;
        if (view.long_enough)
        begin
            if (is_jpeg)
            begin
                result.status = ihsp_pkg::ST_FOUND;
                result.format = ihsp_pkg::FMT_JPEG;
                result.height = {16'd0, v[7], v[8]};
                result.width  = {16'd0, v[9], v[10]};
            end
            else if (is_gif)
            begin
                result.status = ihsp_pkg::ST_FOUND;
                result.format = ihsp_pkg::FMT_GIF;
                result.width  = {16'd0, v[7], v[6]};
                result.height = {16'd0, v[9], v[8]};
            end
            else if (is_png)
            begin
                result.status = ihsp_pkg::ST_FOUND;
                result.format = ihsp_pkg::FMT_PNG;
                result.width  = {v[16], v[17], v[18], v[19]};
                result.height = {v[20], v[21], v[22], v[23]};
            end
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench for image_header_size_parser: streams GIF, PNG, JPEG and junk files byte by byte.
// Depends on ihsp_pkg, ihsp_byte_if, ihsp_result_if and the image_header_size_parser RTL.
// A scoreboard class predicts each file's size result and checks the result channel.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_BITS    = 32;
    localparam int CLK_PERIOD     = 12;
    localparam int RESULT_LATENCY = 2;
    localparam int BYTE_TARGET    = 1100;
    localparam int QUIET_PART     = 950;
    localparam int LONG_HOLD      = 400;
    localparam int STALL_LIMIT    = 4000;

    // Predicts the size result of each file and checks the words that come out
    class size_scoreboard;
        longint unsigned        ofs_max;
        longint unsigned        bytes_seen;
        longint unsigned        window_at;
        logic [7:0]             header [ihsp_pkg::HEADER_LEN];
        logic [7:0]             window [ihsp_pkg::WINDOW_LEN];
        logic [7:0]             recent [ihsp_pkg::WINDOW_LEN];
        ihsp_pkg::scan_phase_t  phase;
        ihsp_pkg::result_t      expected_sizes [$];
        int                     error_count;
        int                     jpeg_seen;
        int                     gif_seen;
        int                     png_seen;
        int                     rejected_seen;

        function new(int offset_bits);
            ofs_max = (offset_bits >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                          : (64'd1 << offset_bits) - 64'd1;
            error_count = 0;
            jpeg_seen = 0;
            gif_seen = 0;
            png_seen = 0;
            rejected_seen = 0;
            start_file();
        endfunction

        function void start_file();
            bytes_seen = 0;
            window_at = 2;
            phase = ihsp_pkg::PH_IDLE;
            foreach (header[i]) header[i] = 8'h00;
            foreach (window[i]) window[i] = 8'h00;
            foreach (recent[i]) recent[i] = 8'h00;
        endfunction

        function bit is_frame_marker(logic [7:0] m);
            return (m >= ihsp_pkg::B_SOF0 && m <= ihsp_pkg::B_SOF3) ||
                   (m >= ihsp_pkg::B_SOF9 && m <= ihsp_pkg::B_SOF11);
        endfunction

        // End the walk at a frame marker, a bad window or a window end out of range, else aim at the next segment
        function void judge_window();
            longint unsigned seg_step;
            if (window[0] != ihsp_pkg::B_FF || is_frame_marker(window[1]))
            begin
                phase = ihsp_pkg::PH_DONE;
                return;
            end
            seg_step = 2 + {window[2], window[3]};
            if (window_at > ofs_max - 11 - seg_step)
            begin
                phase = ihsp_pkg::PH_DONE;
                return;
            end
            window_at += seg_step;
            phase = ihsp_pkg::PH_WAIT;
        endfunction

        function int pending();
            return expected_sizes.size();
        endfunction

        // Advance the parse by one accepted byte; queue a result on the last one
        function void take_byte(logic [7:0] b, logic fin);
            longint unsigned   at;
            logic [7:0]        v [ihsp_pkg::HEADER_LEN];
            ihsp_pkg::result_t r;
            at = bytes_seen;
            if (at < ihsp_pkg::HEADER_LEN)
                header[at] = b;
            for (int i = 0; i < ihsp_pkg::WINDOW_LEN - 1; i++)
                recent[i] = recent[i + 1];
            recent[ihsp_pkg::WINDOW_LEN - 1] = b;

            if (at == ihsp_pkg::FIRST_WINDOW_END)
            begin
                for (int i = 0; i < ihsp_pkg::WINDOW_LEN; i++)
                    window[i] = header[i + 2];
                if (header[0] == ihsp_pkg::B_FF && header[1] == ihsp_pkg::B_SOI &&
                    header[2] == ihsp_pkg::B_FF && header[3] == ihsp_pkg::B_APP0 &&
                    header[6] == ihsp_pkg::C_J && header[7] == ihsp_pkg::C_F &&
                    header[8] == ihsp_pkg::C_I && header[9] == ihsp_pkg::C_F)
                    judge_window();
                else
                    phase = ihsp_pkg::PH_DONE;
            end
            else if (phase == ihsp_pkg::PH_WAIT && at == window_at + 11)
            begin
                foreach (window[i]) window[i] = recent[i];
                judge_window();
            end

            if (bytes_seen < ofs_max)
                bytes_seen++;
            if (!fin)
                return;

            r.status = ihsp_pkg::ST_FAIL;
            r.format = ihsp_pkg::FMT_NONE;
            r.width  = '0;
            r.height = '0;
            if (bytes_seen >= ihsp_pkg::HEADER_LEN)
            begin
                foreach (v[i]) v[i] = header[i];
                for (int i = 0; i < ihsp_pkg::WINDOW_LEN; i++)
                    v[i + 2] = window[i];
                if (v[0] == ihsp_pkg::B_FF && v[1] == ihsp_pkg::B_SOI &&
                    v[2] == ihsp_pkg::B_FF)
                begin
                    r.status = ihsp_pkg::ST_FOUND;
                    r.format = ihsp_pkg::FMT_JPEG;
                    r.height = {16'h0, v[7], v[8]};
                    r.width  = {16'h0, v[9], v[10]};
                end
                else if (v[0] == ihsp_pkg::C_G && v[1] == ihsp_pkg::C_I &&
                         v[2] == ihsp_pkg::C_F)
                begin
                    r.status = ihsp_pkg::ST_FOUND;
                    r.format = ihsp_pkg::FMT_GIF;
                    r.width  = {16'h0, v[7], v[6]};
                    r.height = {16'h0, v[9], v[8]};
                end
                else if (v[0] == ihsp_pkg::B_PNG0 && v[1] == ihsp_pkg::C_P &&
                         v[2] == ihsp_pkg::C_N && v[3] == ihsp_pkg::C_G &&
                         v[4] == ihsp_pkg::B_CR && v[5] == ihsp_pkg::B_LF &&
                         v[6] == ihsp_pkg::B_SUB && v[7] == ihsp_pkg::B_LF &&
                         v[12] == ihsp_pkg::C_I && v[13] == ihsp_pkg::C_H &&
                         v[14] == ihsp_pkg::C_D && v[15] == ihsp_pkg::C_R)
                begin
                    r.status = ihsp_pkg::ST_FOUND;
                    r.format = ihsp_pkg::FMT_PNG;
                    r.width  = {v[16], v[17], v[18], v[19]};
                    r.height = {v[20], v[21], v[22], v[23]};
                end
            end
            expected_sizes.push_back(r);
            start_file();
        endfunction

        // Compare one result word with the oldest predicted size
        function void check_result(ihsp_pkg::result_t got);
            ihsp_pkg::result_t want;
            if (expected_sizes.size() == 0)
            begin
                $display("%0t: result with no file pending: status %0d format %0d %0dx%0d",
                         $time, got.status, got.format, got.width, got.height);
                error_count++;
                return;
            end
            want = expected_sizes.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, actual %0d",
                         $time, want.status, got.status);
                error_count++;
            end
            if (got.format !== want.format)
            begin
                $display("%0t: format expected %0d, actual %0d",
                         $time, want.format, got.format);
                error_count++;
            end
            if (got.width !== want.width)
            begin
                $display("%0t: width expected %0d, actual %0d",
                         $time, want.width, got.width);
                error_count++;
            end
            if (got.height !== want.height)
            begin
                $display("%0t: height expected %0d, actual %0d",
                         $time, want.height, got.height);
                error_count++;
            end
            if (want.status == ihsp_pkg::ST_FAIL)
                rejected_seen++;
            else if (want.format == ihsp_pkg::FMT_JPEG)
                jpeg_seen++;
            else if (want.format == ihsp_pkg::FMT_GIF)
                gif_seen++;
            else
                png_seen++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ihsp_byte_if   in_if ();
    ihsp_result_if out_if ();

    image_header_size_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .file_bytes(in_if.sink),
        .size_info (out_if.source)
    );

    size_scoreboard board = new(OFFSET_BITS);

    logic [7:0] image_buf [$];
    int         bytes_sent;
    int         files_sent;
    bit         sender_idle_en;
    bit         sink_idle_en;
    bit         hold_request;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Random half the time, else the all-zero or the all-one extreme
    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 3))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Fill with random bytes or cut back to the given length
    function automatic void pad_to(int len);
        while (image_buf.size() < len)
            image_buf.push_back(rand_byte());
        while (image_buf.size() > len)
            void'(image_buf.pop_back());
    endfunction

    function automatic void build_gif(logic [15:0] w, logic [15:0] h, int len, bit corrupt);
        int k;
        image_buf = {ihsp_pkg::C_G, ihsp_pkg::C_I, ihsp_pkg::C_F, 8'h38, 8'h39, 8'h61,
                     w[7:0], w[15:8], h[7:0], h[15:8]};
        if (corrupt)
        begin
            k = $urandom_range(0, 2);
            image_buf[k] = image_buf[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        pad_to(len);
    endfunction

    function automatic void build_png(logic [31:0] w, logic [31:0] h, int len, bit corrupt);
        int k;
        image_buf = {ihsp_pkg::B_PNG0, ihsp_pkg::C_P, ihsp_pkg::C_N, ihsp_pkg::C_G,
                     ihsp_pkg::B_CR, ihsp_pkg::B_LF, ihsp_pkg::B_SUB, ihsp_pkg::B_LF,
                     8'h00, 8'h00, 8'h00, 8'h0D,
                     ihsp_pkg::C_I, ihsp_pkg::C_H, ihsp_pkg::C_D, ihsp_pkg::C_R,
                     w[31:24], w[23:16], w[15:8], w[7:0],
                     h[31:24], h[23:16], h[15:8], h[7:0]};
        if (corrupt)
        begin
            // flip a bit in the signature or the chunk name
            k = $urandom_range(0, 11);
            if (k >= 8)
                k += 4;
            image_buf[k] = image_buf[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        pad_to(len);
    endfunction

    // SOI, APP0 carrying JFIF, some other segments, then a frame header when with_frame is set
    function automatic void build_jfif(int app_len, int extra_segs, bit with_frame,
                                       bit broken, logic [15:0] h, logic [15:0] w);
        logic [7:0]  sig [5];
        logic [15:0] len16;
        logic [7:0]  mark;
        int          seg_len;
        int          bad_seg;
        sig = '{ihsp_pkg::C_J, ihsp_pkg::C_F, ihsp_pkg::C_I, ihsp_pkg::C_F, 8'h00};
        len16 = 16'(app_len);
        image_buf = {ihsp_pkg::B_FF, ihsp_pkg::B_SOI, ihsp_pkg::B_FF, ihsp_pkg::B_APP0,
                     len16[15:8], len16[7:0]};
        for (int k = 0; k < app_len - 2; k++)
            image_buf.push_back(k < 5 ? sig[k] : rand_byte());
        bad_seg = broken ? $urandom_range(0, extra_segs) : -1;
        for (int s = 0; s < extra_segs; s++)
        begin
            seg_len = $urandom_range(2, 30);
            mark = rand_byte();
            // move frame markers out of the C0..CB range
            if (mark >= ihsp_pkg::B_SOF0 && mark <= ihsp_pkg::B_SOF11)
                mark = mark ^ 8'h20;
            image_buf.push_back(s == bad_seg ? (rand_byte() & 8'hFE) : ihsp_pkg::B_FF);
            image_buf.push_back(mark);
            image_buf.push_back(8'h00);
            image_buf.push_back(8'(seg_len));
            for (int k = 0; k < seg_len - 2; k++)
                image_buf.push_back(rand_byte());
        end
        if (with_frame)
        begin
            mark = $urandom_range(0, 1) ? ihsp_pkg::B_SOF0 + 8'($urandom_range(0, 3))
                                        : ihsp_pkg::B_SOF9 + 8'($urandom_range(0, 2));
            image_buf.push_back(bad_seg == extra_segs ? (rand_byte() & 8'hFE)
                                                      : ihsp_pkg::B_FF);
            image_buf.push_back(mark);
            image_buf.push_back(8'h00);
            image_buf.push_back(8'h11);
            image_buf.push_back(8'h08);
            image_buf.push_back(h[15:8]);
            image_buf.push_back(h[7:0]);
            image_buf.push_back(w[15:8]);
            image_buf.push_back(w[7:0]);
            for (int k = 0; k < 10; k++)
                image_buf.push_back(rand_byte());
        end
        pad_to(image_buf.size() + $urandom_range(0, 6));
    endfunction

    // SOI without a JFIF APP0: size read from the first bytes as they are
    function automatic void build_plain_soi(int len);
        image_buf = {ihsp_pkg::B_FF, ihsp_pkg::B_SOI, ihsp_pkg::B_FF, rand_byte()};
        pad_to(len);
    endfunction

    // Offer one byte word and hold it until the parser takes it
    task automatic send_word(input logic [7:0] b, input logic fin);
        if (sender_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last      <= fin;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        board.take_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (image_buf[i])
            send_word(image_buf[i], i == image_buf.size() - 1);
        files_sent++;
    endtask

    // Stop offering until every predicted size has come back
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Pick one file from the random mix
    task automatic random_file();
        int sel;
        int app_len;
        bit huge;
        sel = $urandom_range(0, 19);
        if (sel < 8)
        begin
            huge = $urandom_range(0, 19) == 0;
            app_len = ($urandom_range(0, 9) < 7) ? 16 : $urandom_range(0, 40);
            if (huge)
                app_len = $urandom_range(16'h8000, 16'hFFFF);
            build_jfif(app_len, $urandom_range(0, 3), $urandom_range(0, 7) != 0,
                       $urandom_range(0, 9) == 0, 16'(rand_size()), 16'(rand_size()));
            if (huge)
                pad_to($urandom_range(14, 80));
            else if ($urandom_range(0, 6) == 0)
                pad_to($urandom_range(1, image_buf.size()));
        end
        else if (sel < 11)
            build_gif(16'(rand_size()), 16'(rand_size()), $urandom_range(20, 40),
                      $urandom_range(0, 9) == 0);
        else if (sel < 14)
            build_png(rand_size(), rand_size(), $urandom_range(20, 40),
                      $urandom_range(0, 7) == 0);
        else if (sel < 16)
            build_plain_soi($urandom_range(20, 36));
        else if (sel < 18)
        begin
            image_buf.delete();
            pad_to($urandom_range(1, 23));
        end
        else
        begin
            image_buf.delete();
            pad_to($urandom_range(1, 48));
        end
        send_file();
    endtask

    // Result side: take and check words, stall in bursts or for one long hold
    initial
    begin
        int                stall_left;
        int                hold_left;
        ihsp_pkg::result_t got;
        stall_left = 0;
        hold_left = 0;
        out_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_if.valid && out_if.ready)
            begin
                got.status = out_if.status;
                got.format = ihsp_pkg::format_t'(out_if.format);
                got.width  = out_if.width;
                got.height = out_if.height;
                board.check_result(got);
            end
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_if.ready <= 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        bytes_sent = 0;
        files_sent = 0;
        sender_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        hold_request = 1'b0;
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= 8'h00;
        in_if.last      <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte file, short and exact-length headers, size extremes
        image_buf = {8'hFF};
        send_file();
        build_gif(16'hFFFF, 16'h0000, 24, 1'b0);
        send_file();
        build_gif(16'h0000, 16'hFFFF, 23, 1'b0);
        send_file();
        build_png(32'hFFFF_FFFF, 32'h0000_0001, 24, 1'b0);
        send_file();
        build_png(32'h0000_0000, 32'hFFFF_FFFF, 26, 1'b1);
        send_file();
        build_jfif(16, 0, 1'b1, 1'b0, 16'hFFFF, 16'h0000);
        send_file();
        build_jfif(16, 2, 1'b1, 1'b0, 16'h0000, 16'hFFFF);
        send_file();
        // walk broken by a segment or frame header that does not start with FF
        build_jfif(16, 1, 1'b1, 1'b1, 16'h1234, 16'h5678);
        send_file();
        // file ends before the next window is complete
        build_jfif(16'hFFFF, 0, 1'b1, 1'b0, 16'hABCD, 16'h00EF);
        pad_to(40);
        send_file();
        build_plain_soi(24);
        send_file();
        drain_results();

        // Long result stall while short files keep coming
        hold_request = 1'b1;
        for (int i = 0; i < 10; i++)
        begin
            image_buf.delete();
            pad_to($urandom_range(1, 3));
            send_file();
        end
        drain_results();

        // Random files with idle bursts, then a quiet tail with none
        while (bytes_sent < BYTE_TARGET)
        begin
            if (bytes_sent < QUIET_PART)
            begin
                sender_idle_en = $urandom_range(0, 1);
                sink_idle_en = $urandom_range(0, 1);
            end
            else
            begin
                sender_idle_en = 1'b0;
                sink_idle_en = 1'b0;
            end
            random_file();
            if ($urandom_range(0, 11) == 0)
                drain_results();
        end

        drain_results();
        repeat (4 * RESULT_LATENCY + 4) @(posedge clk);

        $display("Parsed %0d bytes in %0d files: %0d JPEG, %0d GIF, %0d PNG, %0d rejected.",
                 bytes_sent, files_sent, board.jpeg_seen, board.gif_seen, board.png_seen,
                 board.rejected_seen);
        $display("Included a %0d-cycle result hold and idle bursts on both channels.",
                 LONG_HOLD);
        if (board.error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ihsp_pkg.sv
src/ihsp_byte_if.sv
src/ihsp_result_if.sv
src/ihsp_track.sv
src/ihsp_decode.sv
src/image_header_size_parser.sv
test/tb.sv
